>>> hdl/llja_pkg.sv
// Shared types, constants and request/response formats for the least-loaded job assigner.
package llja_pkg;

   localparam int DEFAULT_MAX_SERVERS = 16;

   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 4;
   localparam int RATE_W  = 8;
   localparam int ITEMS_W = 8;
   localparam int BUSY_W  = 32;
   localparam int CFG_W   = 5;
   localparam int PROD_W  = RATE_W + ITEMS_W;

   localparam logic [CFG_W-1:0] NUM_CASHIERS_RESET = CFG_W'(16);

   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] server_index;
      logic [RATE_W-1:0]  rate;
      logic [ITEMS_W-1:0] items;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] chosen_server;
      logic [BUSY_W-1:0]  server_busy;
      logic [BUSY_W-1:0]  makespan;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // request taken this cycle
      logic scan;       // one busy-time compare step
      logic rate_rd;    // fetch rate of the winning server
      logic update;     // add job, write back, respond
      logic load_resp;  // respond to a rate load
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

>>> hdl/llja_ram.sv
// Generic single-write, single-read RAM with registered read data.
module llja_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/llja_ctrl.sv
// Sequencing state machine for the least-loaded job assigner.
module llja_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [llja_pkg::FUNC_W-1:0] req_func,
   input  llja_pkg::status_type       status,
   output llja_pkg::cmd_type          cmd,
   output logic                       busy
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_RATE = 5'b01000,
      ST_UPD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == llja_pkg::FUNC_LOAD) begin
                  state_in = ST_LOAD;
               end else if (req_func == llja_pkg::FUNC_ASSIGN) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_RATE;
            end
         end
         ST_RATE: state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.accept    = accept;
      cmd.scan      = (state_ff == ST_SCAN);
      cmd.rate_rd   = (state_ff == ST_RATE);
      cmd.update    = (state_ff == ST_UPD);
      cmd.load_resp = (state_ff == ST_LOAD);
   end

   assign busy = (state_ff != ST_IDLE);

   // scan only ends into the rate fetch
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && status.scan_done |=> (state_ff == ST_RATE))
      else $error("scan did not hand over to rate fetch");

   // an update always returns to idle
   a_upd_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> !busy)
      else $error("block still busy after update");

   // a plain request never leaves idle
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      accept && (req_func != llja_pkg::FUNC_LOAD) && (req_func != llja_pkg::FUNC_ASSIGN)
      |=> !busy)
      else $error("clear or unused code left idle");

endmodule

>>> hdl/llja_dp.sv
// Datapath: busy-time and rate RAMs, minimum scan, job update and response register.
module llja_dp #(
   parameter int MAX_SERVERS = llja_pkg::DEFAULT_MAX_SERVERS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  llja_pkg::req_type           req_data,
   input  llja_pkg::cmd_type           cmd,
   input  logic                        csr_wr,
   input  logic [llja_pkg::CFG_W-1:0]  csr_data,
   output llja_pkg::status_type        status,
   output logic                        rsp_strobe,
   output llja_pkg::rsp_type           rsp_data
);

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);
   localparam int NW    = (CNT_W > llja_pkg::CFG_W) ? CNT_W : llja_pkg::CFG_W;
   localparam int IW    = (CNT_W > llja_pkg::INDEX_W) ? CNT_W : llja_pkg::INDEX_W;
   localparam int BW    = llja_pkg::BUSY_W;

   // config and architectural state
   logic [llja_pkg::CFG_W-1:0] num_ff;
   logic [MAX_SERVERS-1:0]     busy_vld_ff;
   logic [MAX_SERVERS-1:0]     rate_vld_ff;
   logic [BW-1:0]              max_ff;

   // working registers
   llja_pkg::req_type req_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [BW-1:0]     best_ff;
   logic              rsp_valid_ff;
   llja_pkg::rsp_type rsp_ff;

   // ram ports
   logic                       busy_rd_en, busy_wr_en;
   logic [IDX_W-1:0]           busy_rd_addr;
   logic [BW-1:0]              busy_rd_data, busy_wr_data;
   logic                       rate_wr_en;
   logic [llja_pkg::RATE_W-1:0] rate_rd_data;

   logic [NW-1:0]    num_wide;
   logic [CNT_W-1:0] n_active;
   logic             idx_ok;
   logic [IDX_W-1:0] req_idx;
   logic [BW-1:0]    cur_busy;
   logic             scan_last;
   logic             better;
   logic [llja_pkg::RATE_W-1:0] cur_rate;
   logic [llja_pkg::PROD_W-1:0] prod;
   logic [BW:0]      sum;
   logic [BW-1:0]    new_busy;
   logic [BW-1:0]    new_max;
   logic             is_load, is_assign, is_clear;

   // servers in search: zero counts as one, clamp at the array size
   always_comb begin
      num_wide = NW'(num_ff);
      if (num_wide == '0) begin
         n_active = CNT_W'(1);
      end else if (num_wide > NW'(MAX_SERVERS)) begin
         n_active = CNT_W'(MAX_SERVERS);
      end else begin
         n_active = CNT_W'(num_wide);
      end
   end

   assign is_load   = (req_data.func == llja_pkg::FUNC_LOAD);
   assign is_assign = (req_data.func == llja_pkg::FUNC_ASSIGN);
   assign is_clear  = (req_data.func == llja_pkg::FUNC_CLEAR);
   assign idx_ok    = IW'(req_data.server_index) < IW'(MAX_SERVERS);
   assign req_idx   = IDX_W'(req_data.server_index);

   assign cur_busy  = busy_vld_ff[rd_idx_ff] ? busy_rd_data : '0;
   assign scan_last = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == n_active;
   assign better    = (rd_idx_ff == '0) || (cur_busy < best_ff);
   assign status.scan_done = scan_last;

   // busy RAM read: scan start, scan step, or load echo
   always_comb begin
      busy_rd_en   = 1'b0;
      busy_rd_addr = '0;
      if (cmd.accept && is_assign) begin
         busy_rd_en = 1'b1;
      end else if (cmd.accept && is_load && idx_ok) begin
         busy_rd_en   = 1'b1;
         busy_rd_addr = req_idx;
      end else if (cmd.scan && !scan_last) begin
         busy_rd_en   = 1'b1;
         busy_rd_addr = rd_idx_ff + IDX_W'(1);
      end
   end

   // job update with saturation
   assign cur_rate     = rate_vld_ff[best_idx_ff] ? rate_rd_data : '0;
   assign prod         = llja_pkg::PROD_W'(req_ff.items) * llja_pkg::PROD_W'(cur_rate);
   assign sum          = {1'b0, best_ff} + (BW+1)'(prod);
   assign new_busy     = sum[BW] ? '1 : sum[BW-1:0];
   assign new_max      = (new_busy > max_ff) ? new_busy : max_ff;
   assign busy_wr_en   = cmd.update;
   assign busy_wr_data = new_busy;
   assign rate_wr_en   = cmd.accept && is_load && idx_ok;

   llja_ram #(.WIDTH(BW), .DEPTH(MAX_SERVERS)) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_wr_en),
      .wr_addr (best_idx_ff),
      .wr_data (busy_wr_data),
      .rd_en   (busy_rd_en),
      .rd_addr (busy_rd_addr),
      .rd_data (busy_rd_data)
   );

   llja_ram #(.WIDTH(llja_pkg::RATE_W), .DEPTH(MAX_SERVERS)) u_rate_ram (
      .clock   (clock),
      .wr_en   (rate_wr_en),
      .wr_addr (req_idx),
      .wr_data (req_data.rate),
      .rd_en   (cmd.rate_rd),
      .rd_addr (best_idx_ff),
      .rd_data (rate_rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= llja_pkg::NUM_CASHIERS_RESET;
         busy_vld_ff  <= '0;
         rate_vld_ff  <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            num_ff <= csr_data;
         end
         if (rate_wr_en) begin
            rate_vld_ff[req_idx] <= 1'b1;
         end
         if (cmd.accept && is_clear) begin
            busy_vld_ff <= '0;
            max_ff      <= '0;
         end
         if (cmd.update) begin
            busy_vld_ff[best_idx_ff] <= 1'b1;
            max_ff                   <= new_max;
         end
         rsp_valid_ff <= (cmd.accept && !is_load && !is_assign) || cmd.load_resp ||
                         cmd.update;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff    <= req_data;
         rd_idx_ff <= is_load ? req_idx : '0;
      end else if (cmd.scan && !scan_last) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
      if (cmd.scan && better) begin
         best_ff     <= cur_busy;
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.accept) begin
         rsp_ff.chosen_server <= '0;
         rsp_ff.server_busy   <= '0;
         rsp_ff.makespan      <= is_clear ? '0 : max_ff;
      end else if (cmd.load_resp) begin
         rsp_ff.chosen_server <= req_ff.server_index;
         rsp_ff.server_busy   <= (IW'(req_ff.server_index) < IW'(MAX_SERVERS)) ? cur_busy
                                                                                 : '0;
         rsp_ff.makespan      <= max_ff;
      end else if (cmd.update) begin
         rsp_ff.chosen_server <= llja_pkg::INDEX_W'(best_idx_ff);
         rsp_ff.server_busy   <= new_busy;
         rsp_ff.makespan      <= new_max;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // winner must lie inside the active range
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rate_rd |-> CNT_W'(best_idx_ff) < n_active)
      else $error("chosen server outside active range");

   // makespan never below the busy time just reported
   a_makespan: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (max_ff >= rsp_ff.server_busy) && (rsp_ff.makespan == max_ff))
      else $error("makespan below updated busy time");

   // clear empties all busy times
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && is_clear |=> (busy_vld_ff == '0) && (max_ff == '0) && rsp_strobe)
      else $error("clear did not reset busy times");

endmodule

>>> hdl/least_loaded_job_assigner_core.sv
// Top level of the least-loaded job assigner: controller, datapath and port wiring.
//
// Greedy list scheduler. Each request either loads one server's per-item rate, assigns a
// job to the server with the smallest busy time among the first num_cashiers servers
// (lowest index wins ties; busy time grows by items * rate, saturating at all ones), or
// clears all busy times and the makespan. A request is taken when start is high and busy
// is low. Every request gives exactly one response, shown on rsp_data for one cycle with
// rsp_strobe high; the receiver cannot stall, so it must take it in that cycle.
// Clear and the unused function code register their response from the accepting cycle, a
// rate load responds from the load state, and an assign passes through the scan, rate-read
// and update states. The assign scans the busy-time RAM, whose single read port is read
// one server per cycle, then reads the winner's rate and updates. busy drops as the
// response is registered, so the next request may be taken while the strobe is up. Busy
// times and rates live in RAMs; per-entry valid bits give zero for entries never written
// since reset (or since a clear, for busy times), so there is no clearing pass.
// num_cashiers is written over the csr channel, which is ready only while the block is
// idle and no request is offered; zero acts as one and values above MAX_SERVERS act as
// MAX_SERVERS.
module least_loaded_job_assigner_core #(
   parameter int MAX_SERVERS = llja_pkg::DEFAULT_MAX_SERVERS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  llja_pkg::req_type          req_data,
   // response channel
   output logic                       rsp_strobe,
   output llja_pkg::rsp_type          rsp_data,
   // num_cashiers register
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [llja_pkg::CFG_W-1:0] csr_data
);

   llja_pkg::cmd_type    cmd;
   llja_pkg::status_type status;
   logic                 csr_wr;

   // never in the same cycle as a request being taken
   assign csr_ready = !busy && !start;
   assign csr_wr    = csr_valid && csr_ready;

   llja_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   llja_dp #(.MAX_SERVERS(MAX_SERVERS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .csr_wr     (csr_wr),
      .csr_data   (csr_data),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
